// File: hw/rtl/ray_box_slab_intersect_assert.svh
// assertion helpers for the slab test block
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// same-cycle implication, sampled on clk, ignored in reset
`define RBSI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbsi assertion failed");

// check of the current result against an earlier cycle
`define RBSI_ASSERT_PAST(lbl, cons, ante) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cons) |-> (ante)) \
    else $error("rbsi timing assertion failed");

`endif

// File: hw/rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int QW         = 32;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = QW + 2;
  localparam int NMAG_W     = QW + 1;
  localparam int DIVD_W     = NMAG_W + FRAC_W;
  localparam int THR_W      = 17;
  localparam int DIV_STAGES = DIVD_W;
  localparam int LANES      = 3;
  // input register, divider stages, lane output, merge output
  localparam int LATENCY    = DIV_STAGES + 3;

  localparam logic [THR_W-1:0]     THR_RESET = 17'd7;
  localparam logic signed [NUM_W-1:0] Q_ONE  = 34'sd65536;
  localparam logic signed [QW-1:0] T_POS_INF = 32'sh7fffffff;
  localparam logic signed [QW-1:0] T_NEG_INF = 32'sh80000000;

  typedef struct packed {
    logic signed [QW-1:0] near_t;
    logic signed [QW-1:0] far_t;
  } slab_t;

  typedef struct packed {
    logic par;
    logic pos_a;
    logic neg_a;
    logic qneg_a;
    logic pos_b;
    logic neg_b;
    logic qneg_b;
  } face_ctl_t;

endpackage

// File: hw/rtl/rbsi_div.sv
`timescale 1ns / 1ps
module rbsi_div (
  input  logic                            clk,
  input  logic [rbsi_pkg::DIVD_W-1:0]     dividend,
  input  logic [rbsi_pkg::QW-1:0]         divisor,
  output logic [rbsi_pkg::DIVD_W-1:0]     quotient
);

  localparam int S = rbsi_pkg::DIV_STAGES;
  localparam int W = rbsi_pkg::QW;
  localparam int N = rbsi_pkg::DIVD_W;

  // one quotient bit per stage, restoring
  logic [W-1:0] rem [0:S];
  logic [N-1:0] dq  [0:S];
  logic [W-1:0] dv  [0:S];

  assign rem[0] = '0;
  assign dq[0]  = dividend;
  assign dv[0]  = divisor;

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [W:0] trial;
    logic       take;
    assign trial = {rem[k], dq[k][N-1]};
    assign take  = trial >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      rem[k+1] <= take ? W'(trial - {1'b0, dv[k]}) : trial[W-1:0];
      dq[k+1]  <= {dq[k][N-2:0], take};
      dv[k+1]  <= dv[k];
    end
  end

  assign quotient = dq[S];

endmodule

// File: hw/rtl/rbsi_lane.sv
`timescale 1ns / 1ps
module rbsi_lane (
  input  logic                              clk,
  input  logic signed [rbsi_pkg::QW-1:0]    origin,
  input  logic signed [rbsi_pkg::QW-1:0]    dir,
  input  logic [rbsi_pkg::THR_W-1:0]        threshold,
  output rbsi_pkg::slab_t                   slab
);

  localparam int S = rbsi_pkg::DIV_STAGES;
  localparam int W = rbsi_pkg::QW;

  logic signed [rbsi_pkg::NUM_W-1:0] o_ext, num_a, num_b;
  logic [rbsi_pkg::NUM_W-1:0]        mag_a, mag_b;
  logic [W-1:0]                      d_mag;
  rbsi_pkg::face_ctl_t               ctl_in;

  always_comb begin
    o_ext  = {{2{origin[W-1]}}, origin};
    num_a  = -rbsi_pkg::Q_ONE - o_ext;
    num_b  = rbsi_pkg::Q_ONE - o_ext;
    mag_a  = num_a[rbsi_pkg::NUM_W-1] ? -num_a : num_a;
    mag_b  = num_b[rbsi_pkg::NUM_W-1] ? -num_b : num_b;
    d_mag  = dir[W-1] ? -dir : dir;
    ctl_in.par    = (dir == '0) || (d_mag < W'(threshold));
    ctl_in.pos_a  = !num_a[rbsi_pkg::NUM_W-1] && (num_a != '0);
    ctl_in.neg_a  = num_a[rbsi_pkg::NUM_W-1];
    ctl_in.qneg_a = num_a[rbsi_pkg::NUM_W-1] ^ dir[W-1];
    ctl_in.pos_b  = !num_b[rbsi_pkg::NUM_W-1] && (num_b != '0);
    ctl_in.neg_b  = num_b[rbsi_pkg::NUM_W-1];
    ctl_in.qneg_b = num_b[rbsi_pkg::NUM_W-1] ^ dir[W-1];
  end

  // input register
  logic [rbsi_pkg::DIVD_W-1:0] divd_a, divd_b;
  logic [W-1:0]                divs;
  rbsi_pkg::face_ctl_t         ctl [0:S];

  always_ff @(posedge clk) begin
    divd_a <= {mag_a[rbsi_pkg::NMAG_W-1:0], {rbsi_pkg::FRAC_W{1'b0}}};
    divd_b <= {mag_b[rbsi_pkg::NMAG_W-1:0], {rbsi_pkg::FRAC_W{1'b0}}};
    divs   <= d_mag;
    ctl[0] <= ctl_in;
  end

  for (genvar k = 0; k < S; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      ctl[k+1] <= ctl[k];
    end
  end

  logic [rbsi_pkg::DIVD_W-1:0] q_a, q_b;

  rbsi_div u_div_a (.clk(clk), .dividend(divd_a), .divisor(divs), .quotient(q_a));
  rbsi_div u_div_b (.clk(clk), .dividend(divd_b), .divisor(divs), .quotient(q_b));

  function automatic logic signed [W-1:0] face_time(
    input logic [rbsi_pkg::DIVD_W-1:0] q,
    input logic qneg, input logic par, input logic pos, input logic neg
  );
    logic signed [W-1:0] r;
    if (par) begin
      r = pos ? rbsi_pkg::T_POS_INF : (neg ? rbsi_pkg::T_NEG_INF : '0);
    end else if (!qneg && q > rbsi_pkg::DIVD_W'(64'd2147483647)) begin
      r = rbsi_pkg::T_POS_INF;
    end else if (qneg && q > rbsi_pkg::DIVD_W'(64'd2147483648)) begin
      r = rbsi_pkg::T_NEG_INF;
    end else begin
      r = qneg ? -q[W-1:0] : q[W-1:0];
    end
    return r;
  endfunction

  logic signed [W-1:0] t_a, t_b;

  always_comb begin
    t_a = face_time(q_a, ctl[S].qneg_a, ctl[S].par, ctl[S].pos_a, ctl[S].neg_a);
    t_b = face_time(q_b, ctl[S].qneg_b, ctl[S].par, ctl[S].pos_b, ctl[S].neg_b);
  end

  always_ff @(posedge clk) begin
    slab.near_t <= (t_a > t_b) ? t_b : t_a;
    slab.far_t  <= (t_a > t_b) ? t_a : t_b;
  end

endmodule

// File: hw/rtl/rbsi_merge.sv
`timescale 1ns / 1ps
module rbsi_merge (
  input  logic                            clk,
  input  rbsi_pkg::slab_t                 slabs [rbsi_pkg::LANES],
  output logic                            hit,
  output logic signed [rbsi_pkg::QW-1:0]  t_enter,
  output logic signed [rbsi_pkg::QW-1:0]  t_exit
);

  logic signed [rbsi_pkg::QW-1:0] enter_c, exit_c;

  always_comb begin
    enter_c = slabs[0].near_t;
    exit_c  = slabs[0].far_t;
    for (int i = 1; i < rbsi_pkg::LANES; i++) begin
      if (slabs[i].near_t > enter_c) enter_c = slabs[i].near_t;
      if (slabs[i].far_t < exit_c)   exit_c  = slabs[i].far_t;
    end
  end

  always_ff @(posedge clk) begin
    hit     <= enter_c <= exit_c;
    t_enter <= enter_c;
    t_exit  <= exit_c;
  end

endmodule

// File: hw/rtl/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// a result strobes done once through the input, divider, lane and merge registers
// throughput: one ray per cycle outside reset, set by each lane's 49-stage dividers
// reset: rst is synchronous, clears the valid pipeline and loads threshold 7
// busy is high only during reset; results cannot be stalled by the receiver
module ray_box_slab_intersect (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              threshold_we,
  input  logic [rbsi_pkg::THR_W-1:0]        threshold_wdata,
  input  logic signed [rbsi_pkg::QW-1:0]    origin_x,
  input  logic signed [rbsi_pkg::QW-1:0]    origin_y,
  input  logic signed [rbsi_pkg::QW-1:0]    origin_z,
  input  logic signed [rbsi_pkg::QW-1:0]    dir_x,
  input  logic signed [rbsi_pkg::QW-1:0]    dir_y,
  input  logic signed [rbsi_pkg::QW-1:0]    dir_z,
  output logic                              done,
  output logic                              hit,
  output logic signed [rbsi_pkg::QW-1:0]    t_enter,
  output logic signed [rbsi_pkg::QW-1:0]    t_exit
);

`include "ray_box_slab_intersect_assert.svh"

  localparam int LAT = rbsi_pkg::LATENCY;

  // parallel-axis threshold register
  logic [rbsi_pkg::THR_W-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rbsi_pkg::THR_RESET;
    end else if (threshold_we) begin
      threshold <= threshold_wdata;
    end
  end

  // nothing holds a ray off except reset
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // transaction valid travels beside the data pipeline
  logic [LAT-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end

  assign done = vpipe[LAT-1];

  // one lane per axis, each with its own pair of dividers
  logic signed [rbsi_pkg::QW-1:0] origins [rbsi_pkg::LANES];
  logic signed [rbsi_pkg::QW-1:0] dirs    [rbsi_pkg::LANES];
  rbsi_pkg::slab_t                slabs   [rbsi_pkg::LANES];

  assign origins[0] = origin_x;
  assign origins[1] = origin_y;
  assign origins[2] = origin_z;
  assign dirs[0]    = dir_x;
  assign dirs[1]    = dir_y;
  assign dirs[2]    = dir_z;

  for (genvar i = 0; i < rbsi_pkg::LANES; i++) begin : g_lane
    rbsi_lane u_lane (
      .clk       (clk),
      .origin    (origins[i]),
      .dir       (dirs[i]),
      .threshold (threshold),
      .slab      (slabs[i])
    );
  end

  // largest entry, smallest exit, hit flag
  rbsi_merge u_merge (
    .clk     (clk),
    .slabs   (slabs),
    .hit     (hit),
    .t_enter (t_enter),
    .t_exit  (t_exit)
  );

  // a result only ever follows an accepted ray by the full latency
  `RBSI_ASSERT_PAST(a_done_latency, done, $past(accept, LAT))

  // hit flag agrees with the ordering of the reported times
  `RBSI_ASSERT_NOW(a_hit_order, done && hit, t_enter <= t_exit)

endmodule
